/* src/fmrt_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-point matrix row transform package
// Word widths, matrix size, opcodes and the pipeline control bundle shared
// by the transform modules.
// ----------------------------------------------------------------------------
package fmrt_pkg;

	localparam int WORD_W    = 32;
	localparam int DIM       = 4;
	localparam int ROW_W     = $clog2(DIM);
	localparam int FRAC_BITS = 16;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef word_t                    row_t [DIM];

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_XFORM = 1'b1
	} op_t;

	typedef struct packed {
		logic adv_s1;
		logic load_we;
		logic in_stall;
	} ctl_t;

endpackage

/* src/fmrt_store.sv */
// ----------------------------------------------------------------------------
// Stored right-hand matrix
// Register file of DIM rows, written one row per load item and presented to
// the lanes as columns.
// ----------------------------------------------------------------------------
module fmrt_store (
	input  logic                      clk,
	input  logic                      we,
	input  logic [fmrt_pkg::ROW_W-1:0] row_index,
	input  fmrt_pkg::row_t            row,
	output fmrt_pkg::row_t            col [fmrt_pkg::DIM]
);
	import fmrt_pkg::*;

	word_t mat_q [DIM][DIM];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int k = 0; k < DIM; k++) begin
				mat_q[row_index][k] <= row[k];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			for (int k = 0; k < DIM; k++) begin
				col[j][k] = mat_q[k][j];
			end
		end
	end

endmodule

/* src/fmrt_lane.sv */
// ----------------------------------------------------------------------------
// Transform lane
// Computes one output element: DIM fixed-point products registered in the
// first stage, then their wrapping sum.
// ----------------------------------------------------------------------------
module fmrt_lane #(
	parameter int FRAC_BITS = fmrt_pkg::FRAC_BITS
) (
	input  logic           clk,
	input  logic           en,
	input  fmrt_pkg::row_t row,
	input  fmrt_pkg::row_t col,
	output fmrt_pkg::word_t sum
);
	import fmrt_pkg::*;

	logic signed [2*WORD_W-1:0] prod [DIM];
	word_t                      prod_s1 [DIM];

	always_comb begin
		for (int k = 0; k < DIM; k++) begin
			prod[k] = (2*WORD_W)'(row[k]) * (2*WORD_W)'(col[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIM; k++) begin
				prod_s1[k] <= prod[k][FRAC_BITS +: WORD_W];
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < DIM; k++) begin
			sum = sum + prod_s1[k];
		end
	end

endmodule

/* src/fmrt_merge.sv */
// ----------------------------------------------------------------------------
// Result merge and flow control
// Collects the lane sums into the output register with the row tag and
// drives the stage valid bits and advance signals.
// ----------------------------------------------------------------------------
module fmrt_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       opcode,
	input  logic [fmrt_pkg::ROW_W-1:0] row_index,
	input  logic                       out_stall,
	input  fmrt_pkg::row_t             sum,
	output fmrt_pkg::ctl_t             ctl,
	output logic                       out_valid,
	output logic [fmrt_pkg::ROW_W-1:0] out_row,
	output fmrt_pkg::row_t             res
);
	import fmrt_pkg::*;

	logic             v_s1;
	logic [ROW_W-1:0] tag_s1;
	logic             out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	word_t            res_q [DIM];
	logic             adv_out;
	logic             adv_s1;
	logic             accept;

	assign adv_out = !out_valid_q || !out_stall;
	assign adv_s1  = !v_s1 || adv_out;
	assign accept  = in_valid && adv_s1;

	assign ctl.adv_s1   = adv_s1;
	assign ctl.load_we  = accept && (opcode == OP_LOAD);
	assign ctl.in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= accept && (opcode == OP_XFORM);
			end
			if (adv_out) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tag_s1 <= row_index;
		end
		if (adv_out && v_s1) begin
			out_row_q <= tag_s1;
			for (int j = 0; j < DIM; j++) begin
				res_q[j] <= sum[j];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;

	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			res[j] = res_q[j];
		end
	end

endmodule

/* src/fixed_matrix4_row_transform.sv */
// ----------------------------------------------------------------------------
// Fixed-point 4x4 matrix row transform
// Load items write one row of the stored matrix; transform items return the
// given row multiplied by the stored matrix, one lane per output element.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   opcode, row_index, elem_a..elem_d
//   out      output     out_valid/out_stall out_row, res_a..res_d
//
// One item is accepted per cycle while in_stall is low; a transform result is
// registered in the product register and then the output register before it appears.
// A load takes effect at its accept edge, so the next item already sees it.
// Reset clears the valid bits only; the stored matrix is undefined until loaded.
// A stall on out holds the result and stalls in only when both stages are full.
// ----------------------------------------------------------------------------
module fixed_matrix4_row_transform #(
	parameter int FRAC_BITS = fmrt_pkg::FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [fmrt_pkg::ROW_W-1:0] row_index,
	input  fmrt_pkg::word_t            elem_a,
	input  fmrt_pkg::word_t            elem_b,
	input  fmrt_pkg::word_t            elem_c,
	input  fmrt_pkg::word_t            elem_d,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [fmrt_pkg::ROW_W-1:0] out_row,
	output fmrt_pkg::word_t            res_a,
	output fmrt_pkg::word_t            res_b,
	output fmrt_pkg::word_t            res_c,
	output fmrt_pkg::word_t            res_d
);
	import fmrt_pkg::*;

	row_t  row;
	row_t  col [DIM];
	row_t  sum;
	row_t  res;
	ctl_t  ctl;

	assign row[0] = elem_a;
	assign row[1] = elem_b;
	assign row[2] = elem_c;
	assign row[3] = elem_d;

	fmrt_store u_store (
		.clk       (clk),
		.we        (ctl.load_we),
		.row_index (row_index),
		.row       (row),
		.col       (col)
	);

	for (genvar j = 0; j < DIM; j++) begin : g_lane
		fmrt_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk (clk),
			.en  (ctl.adv_s1),
			.row (row),
			.col (col[j]),
			.sum (sum[j])
		);
	end

	fmrt_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.row_index (row_index),
		.out_stall (out_stall),
		.sum       (sum),
		.ctl       (ctl),
		.out_valid (out_valid),
		.out_row   (out_row),
		.res       (res)
	);

	assign in_stall = ctl.in_stall;
	assign res_a    = res[0];
	assign res_b    = res[1];
	assign res_c    = res[2];
	assign res_d    = res[3];

endmodule

/* src/fmrt_checker.sv */
// ----------------------------------------------------------------------------
// Matrix row transform port checker
// Watches the top-level ports for handshake and latency rules.
// ----------------------------------------------------------------------------
module fmrt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       opcode,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [fmrt_pkg::ROW_W-1:0] out_row,
	input fmrt_pkg::word_t            res_a
);
	import fmrt_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Stalled output item was dropped.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_row) && $stable(res_a))
		else $error("Stalled output item changed.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("Input stalled while the output side was free.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && opcode == OP_XFORM, 2))
		else $error("Output item without a transform item two cycles earlier.");

endmodule

bind fixed_matrix4_row_transform fmrt_checker u_fmrt_checker (.*);

/* dv/fixed_matrix4_row_transform_checker.sv */
// ----------------------------------------------------------------------------
// Fixed-point matrix row transform checker
// Watches both channels of the block. It keeps its own copy of the stored
// matrix from the accepted load items, and computes the product row of each
// accepted transform item. Each accepted result is then compared, field by
// field and in order, against the oldest product row still waiting.
// ----------------------------------------------------------------------------
module fixed_matrix4_row_transform_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       opcode,
	input  logic [fmrt_pkg::ROW_W-1:0] row_index,
	input  fmrt_pkg::word_t            elem_a,
	input  fmrt_pkg::word_t            elem_b,
	input  fmrt_pkg::word_t            elem_c,
	input  fmrt_pkg::word_t            elem_d,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [fmrt_pkg::ROW_W-1:0] out_row,
	input  fmrt_pkg::word_t            res_a,
	input  fmrt_pkg::word_t            res_b,
	input  fmrt_pkg::word_t            res_c,
	input  fmrt_pkg::word_t            res_d,
	output int                         error_count,
	output int                         pending_count
);
	import fmrt_pkg::*;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		word_t [DIM-1:0]  elem;
	} product_row_t;

	word_t        stored_matrix [DIM][DIM];
	product_row_t product_rows [$];
	int           mismatches = 0;
	string        lane_name [DIM] = '{"res_a", "res_b", "res_c", "res_d"};

	assign error_count = mismatches;

	function automatic word_t fixed_mul(word_t a, word_t b);
		logic signed [2*WORD_W-1:0] wide_a;
		logic signed [2*WORD_W-1:0] wide_b;
		logic signed [2*WORD_W-1:0] shifted;
		wide_a  = (2*WORD_W)'(a);
		wide_b  = (2*WORD_W)'(b);
		shifted = (wide_a * wide_b) >>> FRAC_BITS;
		return shifted[WORD_W-1:0];
	endfunction

	function automatic product_row_t transform_row(logic [ROW_W-1:0] tag,
	                                               word_t [DIM-1:0] lhs);
		product_row_t prod;
		word_t        acc;
		prod.row = tag;
		for (int j = 0; j < DIM; j++) begin
			acc = '0;
			for (int k = 0; k < DIM; k++) begin
				acc = acc + fixed_mul(lhs[k], stored_matrix[k][j]);
			end
			prod.elem[j] = acc;
		end
		return prod;
	endfunction

	task automatic compare_field(string name, logic signed [WORD_W-1:0] want,
	                             logic signed [WORD_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		product_row_t    want;
		word_t [DIM-1:0] actual;
		word_t [DIM-1:0] lhs;
		if (!arst_n) begin
			product_rows.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (product_rows.size() == 0) begin
					mismatches++;
					$error("out_row: expected no result, actual %0d", out_row);
				end else begin
					want   = product_rows.pop_front();
					actual = {res_d, res_c, res_b, res_a};
					compare_field("out_row", WORD_W'(want.row), WORD_W'(out_row));
					for (int j = 0; j < DIM; j++) begin
						compare_field(lane_name[j], want.elem[j], actual[j]);
					end
				end
			end
			if (in_valid && !in_stall) begin
				lhs = {elem_d, elem_c, elem_b, elem_a};
				if (op_t'(opcode) == OP_LOAD) begin
					for (int k = 0; k < DIM; k++) begin
						stored_matrix[row_index][k] = lhs[k];
					end
				end else begin
					product_rows.push_back(transform_row(row_index, lhs));
				end
			end
			pending_count <= product_rows.size();
		end
	end

endmodule

/* dv/fixed_matrix4_row_transform_test.sv */
// ----------------------------------------------------------------------------
// Fixed-point matrix row transform testbench
// Drives load and transform items into the block: a directed opening with
// identity and extreme matrices, then random rows mixing full-range, small
// and extreme values. Both sides pause at random, and the receiver holds off
// once for a long stretch so that the block backs up. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module fixed_matrix4_row_transform_test;
	import fmrt_pkg::*;

	localparam int    ITEMS       = 1750;
	localparam int    IDLE_PCT    = 8;
	localparam int    CALM_FIRST  = 400;
	localparam int    CALM_LAST   = 700;
	localparam int    HOLD_AT     = 1200;
	localparam int    HOLD_CYCLES = 300;
	localparam int    WATCHDOG    = 2000;
	localparam int    DRAIN       = 8;
	localparam word_t WMAX        = 32'sh7FFF_FFFF;
	localparam word_t WMIN        = 32'sh8000_0000;
	localparam word_t ONE         = 32'sh0001_0000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             opcode;
	logic [ROW_W-1:0] row_index;
	word_t            elem_a;
	word_t            elem_b;
	word_t            elem_c;
	word_t            elem_d;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [ROW_W-1:0] out_row;
	word_t            res_a;
	word_t            res_b;
	word_t            res_c;
	word_t            res_d;

	int items_sent   = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	int quiet_cycles = 0;
	int error_count;
	int pending_count;

	fixed_matrix4_row_transform u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.row_index (row_index),
		.elem_a    (elem_a),
		.elem_b    (elem_b),
		.elem_c    (elem_c),
		.elem_d    (elem_d),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_row   (out_row),
		.res_a     (res_a),
		.res_b     (res_b),
		.res_c     (res_c),
		.res_d     (res_d)
	);

	fixed_matrix4_row_transform_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.row_index     (row_index),
		.elem_a        (elem_a),
		.elem_b        (elem_b),
		.elem_c        (elem_c),
		.elem_d        (elem_d),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_row       (out_row),
		.res_a         (res_a),
		.res_b         (res_b),
		.res_c         (res_c),
		.res_d         (res_d),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// The long hold-off lets the sender keep offering items until the block
	// fills and stalls its input.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && items_sent >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (items_sent >= CALM_FIRST && items_sent < CALM_LAST) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG) begin
			$display("fixed_matrix4_row_transform_test: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(op_t op, logic [ROW_W-1:0] idx,
	                         word_t a, word_t b, word_t c, word_t d);
		while (!(items_sent >= CALM_FIRST && items_sent < CALM_LAST)
		       && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		row_index <= idx;
		elem_a    <= a;
		elem_b    <= b;
		elem_c    <= c;
		elem_d    <= d;
		do @(posedge clk); while (in_stall);
		items_sent <= items_sent + 1;
	endtask

	function automatic word_t pick_elem();
		int sel;
		int offs;
		sel = $urandom_range(9);
		if (sel == 0) begin
			case ($urandom_range(4))
				0: return WMAX;
				1: return WMIN;
				2: return '0;
				3: return '1;
				default: return ONE;
			endcase
		end else if (sel <= 4) begin
			return $urandom;
		end
		// Small values within about eight units either side of zero.
		offs = $urandom_range(1048575);
		return offs - 524288;
	endfunction

	initial begin
		in_valid  <= 1'b0;
		opcode    <= OP_LOAD;
		row_index <= '0;
		elem_a    <= '0;
		elem_b    <= '0;
		elem_c    <= '0;
		elem_d    <= '0;
		arst_n    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIM; k++) begin
			send_item(OP_LOAD, ROW_W'(k), (k == 0) ? ONE : '0, (k == 1) ? ONE : '0,
			          (k == 2) ? ONE : '0, (k == 3) ? ONE : '0);
		end
		send_item(OP_XFORM, 2'd0, WMAX, WMIN, '0, '1);
		send_item(OP_XFORM, 2'd1, WMIN, WMAX, 32'sd1, '1);

		// A load is visible to the very next transform item.
		send_item(OP_LOAD, 2'd2, WMAX, WMIN, '1, '0);
		send_item(OP_XFORM, 2'd2, '0, '0, ONE, '0);

		send_item(OP_LOAD, 2'd0, WMAX, WMAX, WMAX, WMAX);
		send_item(OP_LOAD, 2'd1, WMIN, WMIN, WMIN, WMIN);
		send_item(OP_LOAD, 2'd3, '1, 32'sd1, WMIN, WMAX);
		send_item(OP_XFORM, 2'd3, WMAX, WMAX, WMAX, WMAX);
		send_item(OP_XFORM, 2'd0, WMIN, WMIN, WMIN, WMIN);
		send_item(OP_XFORM, 2'd1, WMIN, WMAX, '1, 32'sd1);
		send_item(OP_XFORM, 2'd2, '0, '0, '0, '0);
		send_item(OP_XFORM, 2'd3, 32'sd1, '1, 32'sh0000_8000, ONE);

		while (items_sent < ITEMS) begin
			send_item(($urandom_range(3) == 0) ? OP_LOAD : OP_XFORM,
			          ROW_W'($urandom_range(DIM - 1)),
			          pick_elem(), pick_elem(), pick_elem(), pick_elem());
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (pending_count != 0);
		repeat (DRAIN) @(posedge clk);
		if (pending_count != 0) begin
			$error("%0d expected results never arrived", pending_count);
		end
		if (error_count == 0 && pending_count == 0) begin
			$display("fixed_matrix4_row_transform_test: done, clean");
		end else begin
			$display("fixed_matrix4_row_transform_test: done, errors");
		end
		$finish;
	end

endmodule

/* files.f */
src/fmrt_pkg.sv
src/fmrt_store.sv
src/fmrt_lane.sv
src/fmrt_merge.sv
src/fixed_matrix4_row_transform.sv
src/fmrt_checker.sv
dv/fixed_matrix4_row_transform_checker.sv
dv/fixed_matrix4_row_transform_test.sv
